// ===== rtl/wtw_pkg.sv =====
// Shared types, constants and helpers for the weekly time-window schedule table.
package wtw_pkg;

    localparam int MAX_ENTRIES = 10;
    localparam int HELD_W      = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W       = 4;
    localparam int CMP_W       = (HELD_W > POS_W) ? HELD_W : POS_W;
    localparam int CNT_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int MIN_W       = 11;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [2:0] WEEKDAY_MAX = 3'd6;
    localparam logic [2:0] SUNDAY_IN   = 3'd0;
    localparam logic [2:0] SUNDAY_BIT  = 3'd6;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_START = 2'd1,
        STATUS_BAD_STOP  = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] weekday_mask;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] stop_hour;
        logic [5:0] stop_minute;
        logic [3:0] position;
        logic [2:0] now_weekday;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic       time_valid;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       mow_now;
        logic [3:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [MIN_W-1:0] stop;
        logic [MIN_W-1:0] start;
        logic [6:0]       mask;
    } entry_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       day;
        logic [MIN_W-1:0] now;
        logic             hit;
    } token_t;

    typedef struct packed {
        logic take_left;
        logic take_right;
        logic active;
    } cell_ctl_t;

    function automatic logic [MIN_W-1:0] to_minutes(logic [4:0] hour, logic [5:0] minute);
        logic [MIN_W-1:0] h;
        h = MIN_W'(hour);
        return (h << 6) - (h << 2) + MIN_W'(minute);
    endfunction

endpackage

// ===== rtl/wtw_cell.sv =====
// One schedule cell: holds an entry, shifts with its neighbors, checks the passing query token.
module wtw_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  wtw_pkg::cell_ctl_t ctl,
    input  wtw_pkg::entry_t   left_entry,
    input  wtw_pkg::entry_t   right_entry,
    input  wtw_pkg::token_t   tok_in,
    output wtw_pkg::entry_t   entry,
    output wtw_pkg::token_t   tok
);
    import wtw_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    token_t tok_reg;
    token_t tok_next;
    logic   tok_valid_reg;
    logic   match;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.take_left)
        begin
            entry_next = left_entry;
        end
        else if (ctl.take_right)
        begin
            entry_next = right_entry;
        end
    end

    assign match = ctl.active && entry_reg.mask[tok_in.day]
                   && (tok_in.now >= entry_reg.start) && (tok_in.now < entry_reg.stop);

    always_comb
    begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | (tok_in.valid & match);
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tok_reg   <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_comb
    begin
        tok       = tok_reg;
        tok.valid = tok_valid_reg;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/weekly_time_window_schedule_table.sv =====
// Top level: command decode, entry count, cell chain and response register.
//
// Usage:
//   Command words enter on cmd (cmd_valid / cmd_stall); one response word per
//   command leaves on rsp (rsp_valid / rsp_stall). A word moves at a rising
//   edge where valid is high and stall is low.
//   Add and remove edit the cell chain in the accept cycle: an add shifts every
//   cell back by one and loads the new entry into the first cell, a remove
//   pulls every cell at or after the position forward. Their response word is
//   valid in the cycle after acceptance.
//   A query injects a token into the first cell; the token moves one cell per
//   cycle and ORs in each active cell's match; the hit that leaves the last
//   cell is loaded into the response register.
//   The block takes one command at a time: a new command is taken once the
//   previous response is registered and the response slot is free or leaving.
//   While rsp_stall is high a valid response word holds and cmd_stall rises.
//   Reset empties the table (entry count zero) and clears both valid flags;
//   cell contents are not cleared and are never read before being written.
module weekly_time_window_schedule_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  wtw_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output wtw_pkg::rsp_t rsp
);
    import wtw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [HELD_W-1:0]  held_reg;
    logic [HELD_W-1:0]  held_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               accept;
    logic               walk_done;
    logic               ins_go;
    logic               del_go;
    status_t            add_status;
    entry_t             new_entry;
    token_t             inject;
    logic [CMP_W-1:0]   pos_ext;

    entry_t             entry_q [MAX_ENTRIES];
    token_t             tok_q   [MAX_ENTRIES];
    cell_ctl_t          ctl     [MAX_ENTRIES];

    assign cmd_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = cmd_valid && !cmd_stall;
    assign walk_done = (state_reg == S_WALK) && (cnt_reg == CNT_W'(MAX_ENTRIES - 1));
    assign pos_ext   = CMP_W'(cmd.position);

    always_comb
    begin
        priority if (held_reg >= HELD_W'(MAX_ENTRIES))
        begin
            add_status = STATUS_FULL;
        end
        else if ((cmd.start_hour > HOUR_MAX) || (cmd.start_minute > MINUTE_MAX))
        begin
            add_status = STATUS_BAD_START;
        end
        else if ((cmd.stop_hour > HOUR_MAX) || (cmd.stop_minute > MINUTE_MAX))
        begin
            add_status = STATUS_BAD_STOP;
        end
        else
        begin
            add_status = STATUS_OK;
        end
    end

    assign new_entry.mask  = cmd.weekday_mask;
    assign new_entry.start = to_minutes(cmd.start_hour, cmd.start_minute);
    assign new_entry.stop  = to_minutes(cmd.stop_hour, cmd.stop_minute);

    assign ins_go = accept && (cmd.action == ACT_ADD) && (add_status == STATUS_OK);
    assign del_go = accept && (cmd.action == ACT_REMOVE) && (pos_ext < CMP_W'(held_reg));

    always_comb
    begin
        inject.valid = accept && (cmd.action == ACT_QUERY) && cmd.time_valid
                       && (cmd.now_weekday <= WEEKDAY_MAX);
        inject.day   = (cmd.now_weekday == SUNDAY_IN) ? SUNDAY_BIT : cmd.now_weekday - 3'd1;
        inject.now   = to_minutes(cmd.now_hour, cmd.now_minute);
        inject.hit   = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        if (ins_go)
        begin
            held_next = held_reg + HELD_W'(1);
        end
        else if (del_go)
        begin
            held_next = held_reg - HELD_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_QUERY)
                    begin
                        state_next = S_WALK;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.status      = (cmd.action == ACT_ADD) ? add_status : STATUS_OK;
                        rsp_next.mow_now     = 1'b0;
                        rsp_next.entry_count = 4'(held_next);
                    end
                end
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    state_next           = S_IDLE;
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = STATUS_OK;
                    rsp_next.mow_now     = tok_q[MAX_ENTRIES-1].hit;
                    rsp_next.entry_count = 4'(held_reg);
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            held_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            held_reg      <= held_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        token_t tin;

        assign ctl[g].take_left  = ins_go;
        assign ctl[g].take_right = del_go && (pos_ext <= CMP_W'(g));
        assign ctl[g].active     = held_reg > HELD_W'(g);

        if (g == 0)
        begin : g_head
            assign left_e = new_entry;
            assign tin    = inject;
        end
        else
        begin : g_body
            assign left_e = entry_q[g-1];
            assign tin    = tok_q[g-1];
        end

        if (g == MAX_ENTRIES - 1)
        begin : g_tail
            assign right_e = entry_q[g];
        end
        else
        begin : g_mid
            assign right_e = entry_q[g+1];
        end

        wtw_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl[g]),
            .left_entry  (left_e),
            .right_entry (right_e),
            .tok_in      (tin),
            .entry       (entry_q[g]),
            .tok         (tok_q[g])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the weekly time-window schedule table.
`timescale 1ns / 1ps

module testbench;
    import wtw_pkg::*;

    localparam logic [1:0] ACT_SPARE     = 2'd3;
    localparam int         MINS_PER_HOUR = 60;
    localparam int         RANDOM_WORDS  = 1780;
    localparam int         HOLD_AT       = 500;
    localparam int         DRAIN_AT      = 1100;
    localparam int         CALM_FROM     = 1650;
    localparam int         LONG_HOLD     = 300;
    localparam int         TAIL_CYCLES   = 24;
    localparam int         STALL_LIMIT   = 2000;

    class schedule_checker;
        typedef struct {
            bit [6:0]  days;
            bit [10:0] open_min;
            bit [10:0] close_min;
        } window_t;

        window_t     windows[MAX_ENTRIES];
        int unsigned held;
        rsp_t        awaited[$];
        int unsigned faults;

        function void note_command(cmd_t w);
            rsp_t      r;
            bit [10:0] now_min;
            bit [2:0]  day;
            int        i;
            r = '0;
            case (w.action)
                ACT_ADD:
                begin
                    if (held >= MAX_ENTRIES)
                        r.status = STATUS_FULL;
                    else if (w.start_hour > HOUR_MAX || w.start_minute > MINUTE_MAX)
                        r.status = STATUS_BAD_START;
                    else if (w.stop_hour > HOUR_MAX || w.stop_minute > MINUTE_MAX)
                        r.status = STATUS_BAD_STOP;
                    else
                    begin
                        for (i = int'(held); i > 0; i--)
                            windows[i] = windows[i - 1];
                        windows[0].days      = w.weekday_mask;
                        windows[0].open_min  = 11'(w.start_hour) * 11'(MINS_PER_HOUR)
                                               + 11'(w.start_minute);
                        windows[0].close_min = 11'(w.stop_hour) * 11'(MINS_PER_HOUR)
                                               + 11'(w.stop_minute);
                        held++;
                    end
                end
                ACT_REMOVE:
                begin
                    if (w.position < held)
                    begin
                        for (i = int'(w.position); i + 1 < held; i++)
                            windows[i] = windows[i + 1];
                        held--;
                    end
                end
                ACT_QUERY:
                begin
                    if (w.time_valid && w.now_weekday <= WEEKDAY_MAX)
                    begin
                        day = (w.now_weekday == SUNDAY_IN) ? SUNDAY_BIT : w.now_weekday - 3'd1;
                        now_min = 11'(w.now_hour) * 11'(MINS_PER_HOUR) + 11'(w.now_minute);
                        for (i = 0; i < held; i++)
                            if (windows[i].days[day] && now_min >= windows[i].open_min
                                && now_min < windows[i].close_min)
                                r.mow_now = 1'b1;
                    end
                end
                default: ;
            endcase
            r.entry_count = 4'(held);
            awaited = {awaited, r};
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected response word %p", got);
                faults++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                faults++;
            end
            if (got.mow_now !== want.mow_now)
            begin
                $error("mow_now: expected %0d, got %0d", want.mow_now, got.mow_now);
                faults++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                faults++;
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    bit long_hold_req = 1'b0;
    bit rsp_holding   = 1'b0;
    bit calm          = 1'b0;

    schedule_checker ledger = new();

    weekly_time_window_schedule_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            ledger.check_response(rsp);
    end

    task automatic offer(input cmd_t w);
        cmd       <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        ledger.note_command(w);
    endtask

    function automatic cmd_t noise_word();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(cmd_t)-1:0];
    endfunction

    task automatic add_window(input logic [6:0] mask, input logic [4:0] sh,
                              input logic [5:0] sm, input logic [4:0] th,
                              input logic [5:0] tm);
        cmd_t w;
        w = noise_word();
        w.action       = ACT_ADD;
        w.weekday_mask = mask;
        w.start_hour   = sh;
        w.start_minute = sm;
        w.stop_hour    = th;
        w.stop_minute  = tm;
        offer(w);
    endtask

    task automatic ask(input logic [2:0] wd, input logic [4:0] h, input logic [5:0] m,
                       input logic tv);
        cmd_t w;
        w = noise_word();
        w.action      = ACT_QUERY;
        w.now_weekday = wd;
        w.now_hour    = h;
        w.now_minute  = m;
        w.time_valid  = tv;
        offer(w);
    endtask

    task automatic drop_at(input logic [3:0] pos);
        cmd_t w;
        w = noise_word();
        w.action   = ACT_REMOVE;
        w.position = pos;
        offer(w);
    endtask

    initial
    begin : rsp_side
        bit level;
        int run;
        @(posedge clk);
        forever
        begin
            level = 1'b0;
            run   = 1;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_holding   = 1'b1;
                rsp_stall    <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_holding   = 1'b0;
            end
            else
            begin
                if (!calm)
                begin
                    case ($urandom_range(0, 3))
                        0: begin level = 1'b1; run = int'($urandom_range(1, 12)); end
                        1: run = int'($urandom_range(1, 12));
                        2: run = int'($urandom_range(20, 60));
                        default: run = int'($urandom_range(1, 4));
                    endcase
                end
                rsp_stall <= level;
                repeat (run) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("weekly_time_window_schedule_table regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        cmd_t w;
        int   n;
        int   k;
        int   m;
        int   pick;
        int   gapless;
        bit   growing;
        gapless = 0;
        growing = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        ask(3'd0, 5'd12, 6'd0, 1'b1);
        add_window(7'h7F, 5'd0, 6'd0, 5'd23, 6'd59);
        add_window(7'h40, 5'd8, 6'd30, 5'd9, 6'd0);
        add_window(7'h00, 5'd12, 6'd0, 5'd13, 6'd0);
        add_window(7'h7F, 5'd31, 6'd0, 5'd10, 6'd0);
        add_window(7'h7F, 5'd1, 6'd63, 5'd10, 6'd0);
        add_window(7'h7F, 5'd1, 6'd0, 5'd24, 6'd0);
        add_window(7'h7F, 5'd1, 6'd0, 5'd2, 6'd60);
        add_window(7'h7F, 5'd24, 6'd60, 5'd31, 6'd63);
        add_window(7'h7F, 5'd10, 6'd0, 5'd10, 6'd0);
        ask(3'd0, 5'd8, 6'd30, 1'b1);
        ask(3'd0, 5'd9, 6'd0, 1'b1);
        ask(3'd1, 5'd0, 6'd0, 1'b1);
        ask(3'd6, 5'd23, 6'd59, 1'b1);
        ask(3'd1, 5'd12, 6'd0, 1'b0);
        ask(3'd7, 5'd12, 6'd0, 1'b1);
        ask(3'd2, 5'd31, 6'd63, 1'b1);
        w = noise_word();
        w.action = ACT_SPARE;
        offer(w);
        drop_at(4'd15);
        drop_at(4'(ledger.held));
        drop_at(4'd0);
        drop_at(4'(ledger.held - 1));
        while (ledger.held < MAX_ENTRIES)
            add_window(7'($urandom()), 5'($urandom_range(0, 11)), 6'($urandom_range(0, 59)),
                       5'($urandom_range(12, 23)), 6'($urandom_range(0, 59)));
        add_window(7'h7F, 5'd31, 6'd63, 5'd31, 6'd63);

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 120 == 0)
                growing = !growing;
            if (n == HOLD_AT)
                long_hold_req = 1'b1;
            if (n == CALM_FROM)
                calm = 1'b1;
            w    = noise_word();
            pick = int'($urandom_range(0, 99));
            if (pick < 4)
                w.action = ACT_SPARE;
            else if (pick < (growing ? 50 : 20))
            begin
                w.action = ACT_ADD;
                if ($urandom_range(0, 9) != 0)
                begin
                    w.start_hour   = 5'($urandom_range(0, 23));
                    w.start_minute = 6'($urandom_range(0, 59));
                    w.stop_hour    = 5'($urandom_range(0, 23));
                    w.stop_minute  = 6'($urandom_range(0, 59));
                    if ($urandom_range(0, 3) != 0
                        && {w.start_hour, w.start_minute} > {w.stop_hour, w.stop_minute})
                    begin
                        {w.start_hour, w.start_minute, w.stop_hour, w.stop_minute} =
                            {w.stop_hour, w.stop_minute, w.start_hour, w.start_minute};
                    end
                end
            end
            else if (pick < (growing ? 62 : 65))
            begin
                w.action = ACT_REMOVE;
                if (ledger.held != 0 && $urandom_range(0, 4) != 0)
                    w.position = 4'($urandom_range(0, ledger.held - 1));
            end
            else
            begin
                w.action = ACT_QUERY;
                if ($urandom_range(0, 9) != 0)
                begin
                    w.time_valid  = 1'b1;
                    w.now_weekday = 3'($urandom_range(0, 6));
                    if (ledger.held != 0 && $urandom_range(0, 1) != 0)
                    begin
                        k = int'($urandom_range(0, ledger.held - 1));
                        m = $urandom_range(0, 1) ? int'(ledger.windows[k].open_min)
                                                 : int'(ledger.windows[k].close_min);
                        m = m - int'($urandom_range(0, 1));
                        if (m < 0)
                            m = 0;
                        w.now_hour   = 5'(m / MINS_PER_HOUR);
                        w.now_minute = 6'(m % MINS_PER_HOUR);
                    end
                    else
                    begin
                        w.now_hour   = 5'($urandom_range(0, 23));
                        w.now_minute = 6'($urandom_range(0, 59));
                    end
                end
            end
            offer(w);
            if (n == DRAIN_AT)
            begin
                cmd_valid <= 1'b0;
                @(posedge clk);
                while (ledger.awaited.size() != 0)
                    @(posedge clk);
            end
            else if (!calm && !long_hold_req && !rsp_holding)
            begin
                if (gapless != 0)
                    gapless--;
                else if ($urandom_range(0, 15) == 0)
                    gapless = int'($urandom_range(20, 60));
                else if ($urandom_range(0, 2) == 0)
                begin
                    cmd_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
        end

        cmd_valid <= 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.faults == 0)
            $display("weekly_time_window_schedule_table regression: pass");
        else
            $display("weekly_time_window_schedule_table regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/wtw_pkg.sv
rtl/wtw_cell.sv
rtl/weekly_time_window_schedule_table.sv
sim/testbench.sv
